FILE: hw/rtl/psk_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ps/2 set-1 scancode key decoder
// no dependencies; imported by psk_keymap, psk_mods and the top level
package psk_pkg;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [6:0] KC_UNKNOWN  = 7'd0;
	localparam logic [6:0] KC_ESCAPE   = 7'd57;
	localparam logic [6:0] KC_KP_SLASH = 7'd77;

	// low 7 bits of the modifier and lock keys
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CTRL   = 7'h1D;
	localparam logic [6:0] SC_ALT    = 7'h38;
	localparam logic [6:0] SC_CAPS   = 7'h3A;
	localparam logic [6:0] SC_NUM    = 7'h45;
	localparam logic [6:0] SC_SCROLL = 7'h46;

	// one decoded scancode on its way to the modifier tracker
	typedef struct packed {
		logic       fire;
		logic       ext;
		logic       release_key;
		logic [6:0] low;
	} key_event_t;

	// modifier and lock flags as reported
	typedef struct packed {
		logic scroll;
		logic num;
		logic caps;
		logic alt;
		logic ctrl;
		logic shift;
	} mods_t;

endpackage

FILE: hw/rtl/psk_keymap.sv
`timescale 1ns / 1ps
// scancode to compact key code lookup, plain and extended tables
// depends on psk_pkg
module psk_keymap
	import psk_pkg::*;
(
	input  logic       ext,
	input  logic [6:0] low,
	output logic [6:0] key_code
);

	logic [6:0] plain_code;
	logic [6:0] ext_code;

	// plain (non-prefixed) table
	always_comb begin
		plain_code = KC_UNKNOWN;
		if (low == 7'h01) begin
			plain_code = KC_ESCAPE;
		end else if (low <= 7'h0A) begin
			plain_code = low;
		end else if (low >= 7'h3B && low <= 7'h44) begin
			plain_code = low + 7'd6;
		end else if (low == 7'h57 || low == 7'h58) begin
			plain_code = low - 7'd12;
		end else begin
			case (low)
				7'h0B: plain_code = 7'd1;
				7'h1E: plain_code = 7'd11;
				7'h30: plain_code = 7'd12;
				7'h2E: plain_code = 7'd13;
				7'h20: plain_code = 7'd14;
				7'h12: plain_code = 7'd15;
				7'h21: plain_code = 7'd16;
				7'h22: plain_code = 7'd17;
				7'h23: plain_code = 7'd18;
				7'h17: plain_code = 7'd19;
				7'h24: plain_code = 7'd20;
				7'h25: plain_code = 7'd21;
				7'h26: plain_code = 7'd22;
				7'h32: plain_code = 7'd23;
				7'h31: plain_code = 7'd24;
				7'h18: plain_code = 7'd25;
				7'h19: plain_code = 7'd26;
				7'h10: plain_code = 7'd27;
				7'h13: plain_code = 7'd28;
				7'h1F: plain_code = 7'd29;
				7'h14: plain_code = 7'd30;
				7'h16: plain_code = 7'd31;
				7'h2F: plain_code = 7'd32;
				7'h11: plain_code = 7'd33;
				7'h2D: plain_code = 7'd34;
				7'h15: plain_code = 7'd35;
				7'h2C: plain_code = 7'd36;
				7'h0C: plain_code = 7'd37;
				7'h0D: plain_code = 7'd38;
				7'h1A: plain_code = 7'd39;
				7'h1B: plain_code = 7'd40;
				7'h27: plain_code = 7'd41;
				7'h28: plain_code = 7'd42;
				7'h29: plain_code = 7'd43;
				7'h2B: plain_code = 7'd44;
				7'h33: plain_code = 7'd45;
				7'h34: plain_code = 7'd46;
				7'h35: plain_code = 7'd47;
				7'h37: plain_code = 7'd48;
				7'h4A: plain_code = 7'd49;
				7'h4E: plain_code = 7'd50;
				7'h53: plain_code = 7'd51;
				7'h56: plain_code = 7'd52;
				7'h0E: plain_code = 7'd53;
				7'h0F: plain_code = 7'd54;
				7'h1C: plain_code = 7'd55;
				7'h39: plain_code = 7'd56;
				7'h1D: plain_code = 7'd58;
				7'h2A: plain_code = 7'd59;
				7'h36: plain_code = 7'd60;
				7'h38: plain_code = 7'd61;
				7'h3A: plain_code = 7'd62;
				7'h45: plain_code = 7'd63;
				7'h46: plain_code = 7'd64;
				default: plain_code = KC_UNKNOWN;
			endcase
		end
	end

	// extended (0xe0-prefixed) table
	always_comb begin
		case (low)
			7'h35: ext_code = KC_KP_SLASH;
			7'h1C: ext_code = 7'd78;
			7'h53: ext_code = 7'd79;
			7'h1D: ext_code = 7'd80;
			7'h38: ext_code = 7'd81;
			7'h47: ext_code = 7'd82;
			7'h48: ext_code = 7'd83;
			7'h49: ext_code = 7'd84;
			7'h4B: ext_code = 7'd85;
			7'h4D: ext_code = 7'd86;
			7'h4F: ext_code = 7'd87;
			7'h50: ext_code = 7'd88;
			7'h51: ext_code = 7'd89;
			7'h52: ext_code = 7'd90;
			7'h5B: ext_code = 7'd91;
			7'h5C: ext_code = 7'd92;
			7'h5D: ext_code = 7'd93;
			7'h5E: ext_code = 7'd94;
			7'h5F: ext_code = 7'd95;
			7'h63: ext_code = 7'd96;
			7'h10: ext_code = 7'd97;
			7'h19: ext_code = 7'd98;
			7'h20: ext_code = 7'd99;
			7'h21: ext_code = 7'd100;
			7'h22: ext_code = 7'd101;
			7'h24: ext_code = 7'd102;
			7'h2E: ext_code = 7'd103;
			7'h30: ext_code = 7'd104;
			7'h32: ext_code = 7'd105;
			7'h65: ext_code = 7'd106;
			7'h66: ext_code = 7'd107;
			7'h67: ext_code = 7'd108;
			7'h68: ext_code = 7'd109;
			7'h69: ext_code = 7'd110;
			7'h6A: ext_code = 7'd111;
			7'h6B: ext_code = 7'd112;
			7'h6C: ext_code = 7'd113;
			7'h6D: ext_code = 7'd114;
			default: ext_code = KC_UNKNOWN;
		endcase
	end

	assign key_code = ext ? ext_code : plain_code;

endmodule

FILE: hw/rtl/psk_mods.sv
`timescale 1ns / 1ps
// modifier hold counters and lock toggles, updated once per decoded key
// depends on psk_pkg
module psk_mods
	import psk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  key_event_t ev,
	output mods_t      mods_cur,
	output mods_t      mods_nxt
);

	logic [1:0] shift_cnt_q, shift_cnt_d;
	logic [1:0] ctrl_cnt_q, ctrl_cnt_d;
	logic       alt_q, alt_d;
	logic       caps_q, caps_d;
	logic       num_q, num_d;
	logic       scroll_q, scroll_d;
	logic       is_shift;
	logic       is_ctrl;
	logic       is_alt;

	// key classification; ctrl matches both left and right ctrl
	assign is_shift = !ev.ext && (ev.low == SC_LSHIFT || ev.low == SC_RSHIFT);
	assign is_ctrl  = (ev.low == SC_CTRL);
	assign is_alt   = !ev.ext && (ev.low == SC_ALT);

	// next state, priority as shift, ctrl, alt, locks
	always_comb begin
		shift_cnt_d = shift_cnt_q;
		ctrl_cnt_d  = ctrl_cnt_q;
		alt_d       = alt_q;
		caps_d      = caps_q;
		num_d       = num_q;
		scroll_d    = scroll_q;
		if (ev.fire) begin
			if (ev.release_key) begin
				if (is_shift) begin
					if (shift_cnt_q != 2'd0) shift_cnt_d = shift_cnt_q - 2'd1;
				end else if (is_ctrl) begin
					if (ctrl_cnt_q != 2'd0) ctrl_cnt_d = ctrl_cnt_q - 2'd1;
				end else if (is_alt) begin
					alt_d = 1'b0;
				end
			end else begin
				if (is_shift) begin
					if (shift_cnt_q != 2'd3) shift_cnt_d = shift_cnt_q + 2'd1;
				end else if (is_ctrl) begin
					if (ctrl_cnt_q != 2'd3) ctrl_cnt_d = ctrl_cnt_q + 2'd1;
				end else if (is_alt) begin
					alt_d = 1'b1;
				end else if (!ev.ext && ev.low == SC_CAPS) begin
					caps_d = !caps_q;
				end else if (!ev.ext && ev.low == SC_NUM) begin
					num_d = !num_q;
				end else if (!ev.ext && ev.low == SC_SCROLL) begin
					scroll_d = !scroll_q;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cnt_q <= 2'd0;
			ctrl_cnt_q  <= 2'd0;
			alt_q       <= 1'b0;
			caps_q      <= 1'b0;
			num_q       <= 1'b0;
			scroll_q    <= 1'b0;
		end else begin
			shift_cnt_q <= shift_cnt_d;
			ctrl_cnt_q  <= ctrl_cnt_d;
			alt_q       <= alt_d;
			caps_q      <= caps_d;
			num_q       <= num_d;
			scroll_q    <= scroll_d;
		end
	end

	// flags as they stand now and after this key
	always_comb begin
		mods_cur.shift  = (shift_cnt_q != 2'd0);
		mods_cur.ctrl   = (ctrl_cnt_q != 2'd0);
		mods_cur.alt    = alt_q;
		mods_cur.caps   = caps_q;
		mods_cur.num    = num_q;
		mods_cur.scroll = scroll_q;
		mods_nxt.shift  = (shift_cnt_d != 2'd0);
		mods_nxt.ctrl   = (ctrl_cnt_d != 2'd0);
		mods_nxt.alt    = alt_d;
		mods_nxt.caps   = caps_d;
		mods_nxt.num    = num_d;
		mods_nxt.scroll = scroll_d;
	end

endmodule

FILE: hw/rtl/ps2_scancode_key_decoder.sv
`timescale 1ns / 1ps
// top level of the ps/2 set-1 scancode key decoder: input stage, prefix
// tracking, output register; depends on psk_pkg, psk_keymap, psk_mods
//
// channel   dir  beat content
// s_axis    in   tdata[7:0] scan_byte
// m_axis    out  tdata[15:0] key code, pressed, modifier and lock flags
// cfg       in   data[0] report_enable
//
// one byte per cycle while m_axis is not held; a byte is registered in the input
// stage and its result is then registered in the output register.
// async reset clears prefix, modifier state, report_enable and both valids.
// a held result on m_axis stalls the input stage only when the staged byte
// makes a result; prefix bytes and bytes while disabled always drain.
module ps2_scancode_key_decoder
	import psk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] key_code, [7] pressed, [8] shift_active,
	                                    // [9] ctrl_active, [10] alt_active, [11] caps_on,
	                                    // [12] num_on, [13] scroll_on, [15:14] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data        // [0] report_enable
);

	logic        report_enable_q;
	logic        ext_pending_q;
	logic [7:0]  byte_s1;
	logic        valid_s1;
	logic        is_prefix;
	logic        makes_result;
	logic        advance;
	logic        out_free;
	key_event_t  ev;
	logic [6:0]  key_code;
	mods_t       mods_cur;
	mods_t       mods_nxt;
	logic [15:0] tdata_q;
	logic        tvalid_q;

	// config register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			report_enable_q <= cfg_data;
		end
	end

	// stage control
	assign is_prefix    = (byte_s1 == PREFIX_BYTE);
	assign makes_result = !is_prefix && report_enable_q;
	assign out_free     = !tvalid_q || m_axis_tready;
	assign advance      = valid_s1 && (!makes_result || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// extended prefix: armed by 0xe0, cleared by any other byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_pending_q <= 1'b0;
		end else if (advance) begin
			ext_pending_q <= is_prefix;
		end
	end

	// decoded key event
	always_comb begin
		ev.fire        = advance && makes_result;
		ev.ext         = ext_pending_q;
		ev.release_key = byte_s1[7];
		ev.low         = byte_s1[6:0];
	end

	psk_keymap u_keymap (
		.ext      (ext_pending_q),
		.low      (byte_s1[6:0]),
		.key_code (key_code)
	);

	psk_mods u_mods (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev       (ev),
		.mods_cur (mods_cur),
		.mods_nxt (mods_nxt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_free) begin
			tvalid_q <= ev.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.fire) begin
			tdata_q <= {2'b00, mods_nxt.scroll, mods_nxt.num, mods_nxt.caps,
			            mods_nxt.alt, mods_nxt.ctrl, mods_nxt.shift,
			            !byte_s1[7], key_code};
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;

	// a staged byte only waits when it makes a result and the output is full
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (makes_result && tvalid_q && !m_axis_tready))
		else $error("input stage stalled without a blocked result");

	// a prefix byte leaving the stage arms the extended flag
	a_prefix_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_prefix) |=> ext_pending_q)
		else $error("prefix byte did not arm extended flag");

	// while reporting is off the modifier state does not move
	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !report_enable_q) |=> $stable(mods_cur))
		else $error("modifier state changed while reporting disabled");

	// a new result is loaded only when a staged byte leaves with a result
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && !ev.fire) |=> !tvalid_q)
		else $error("result appeared without a decoded key");

endmodule
